// File: hw/rtl/decint_pkg.sv
// ----------------------------------------------------------------------------
// decint_pkg
// Types, codes and constants shared by the decimal integer parser and its
// checker.
// ----------------------------------------------------------------------------
package decint_pkg;

	// Default accumulator width (magnitude register)
	localparam int ACC_WIDTH_DEF = 64;

	localparam int VALUE_W    = 64;
	localparam int COUNT_W    = 5;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS   = 2'd2;

	// Result width codes
	localparam logic [1:0] WMODE_8  = 2'd0;
	localparam logic [1:0] WMODE_16 = 2'd1;
	localparam logic [1:0] WMODE_32 = 2'd2;
	localparam logic [1:0] WMODE_64 = 2'd3;

	// Configuration reset values
	localparam logic [1:0]         WIDTH_MODE_RST  = WMODE_64;
	localparam logic               SIGNED_MODE_RST = 1'b1;
	localparam logic [COUNT_W-1:0] MAX_CHARS_RST   = 5'd20;

	// Result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_NONE  = 2'd1;
	localparam logic [1:0] STATUS_OVER  = 2'd2;
	localparam logic [1:0] STATUS_UNDER = 2'd3;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		logic [7:0] character;
		logic       start_parse;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [1:0]         status;
		logic [COUNT_W-1:0] consumed;
	} out_item_t;

endpackage

// File: hw/rtl/decimal_integer_parser_saturating_top.sv
// ----------------------------------------------------------------------------
// decimal_integer_parser_saturating_top
// Streaming ASCII decimal integer parser with range saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the text one character per item on the input channel (in_valid,
//   in_stall, in_item). Mark the first character of a parse with
//   start_parse and the last available one with buffer_end. Leading white
//   space and one sign are skipped over, then digits are accumulated. The
//   parse ends at a non-digit (not counted), at max_chars characters or at
//   buffer_end, and then exactly one result item leaves on the output
//   channel (out_valid, out_stall, out_item): value, status, consumed.
//   Characters arriving with no parse open are dropped without a result.
//   An accepted item is loaded into the input register, and its result, if
//   any, moves from there into the result register, which drives out_valid.
//   Throughput is one item per cycle unless the receiver stalls; the limit
//   is the accumulate step (times ten plus digit, then the range check) in
//   the single logic stage between the input and the result register.
//   Reset: parse state goes idle, width_mode 64 bit, signed mode on,
//   max_chars 20. When the receiver stalls, the result register holds; the
//   input register still drains items that produce no result, and stalls
//   only when it holds an item whose result would need the busy register.
//   Configuration is written through cfg_write/cfg_index/cfg_data; the user
//   must write it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module decimal_integer_parser_saturating_top #(
	parameter int ACC_WIDTH = decint_pkg::ACC_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  decint_pkg::in_item_t                 in_item,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output decint_pkg::out_item_t                out_item,
	// configuration
	input  logic                                 cfg_write,
	input  logic [decint_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [decint_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int VW = decint_pkg::VALUE_W;
	localparam int CW = decint_pkg::COUNT_W;

	// configuration registers
	logic [1:0]    width_mode_q;
	logic          signed_mode_q;
	logic [CW-1:0] max_chars_q;

	// input register
	logic                 valid_s1;
	decint_pkg::in_item_t item_s1;

	// parse state
	decint_pkg::phase_t   phase_q, phase_d;
	logic                 neg_q, neg_d;
	logic [ACC_WIDTH-1:0] acc_q, acc_d;
	logic                 beyond_q, beyond_d;
	logic [CW-1:0]        count_q, count_d;

	// result register
	logic                  out_valid_q;
	decint_pkg::out_item_t out_item_q;

	// stage control
	logic emit;
	logic out_free;
	logic advance;
	logic accept;

	// combinational datapath
	decint_pkg::phase_t   phase_e;
	logic                 neg_e;
	logic [ACC_WIDTH-1:0] acc_e;
	logic                 beyond_e;
	logic [CW-1:0]        count_e;
	logic                 is_digit, is_space, is_sign, take;
	logic [3:0]           digit;
	logic [ACC_WIDTH+3:0] prod;
	logic [VW-1:0]        mag, half, umax, num;
	decint_pkg::out_item_t result;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// configuration writes; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode_q  <= decint_pkg::WIDTH_MODE_RST;
			signed_mode_q <= decint_pkg::SIGNED_MODE_RST;
			max_chars_q   <= decint_pkg::MAX_CHARS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				decint_pkg::CFG_WIDTH_MODE:  width_mode_q  <= cfg_data[1:0];
				decint_pkg::CFG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				decint_pkg::CFG_MAX_CHARS:   max_chars_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: load on accept, empty when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	// parse state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= decint_pkg::PH_IDLE;
			neg_q    <= 1'b0;
			acc_q    <= '0;
			beyond_q <= 1'b0;
			count_q  <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			neg_q    <= neg_d;
			acc_q    <= acc_d;
			beyond_q <= beyond_d;
			count_q  <= count_d;
		end
	end

	// next state and result
	always_comb begin
		// a start character clears whatever parse was open
		if (item_s1.start_parse) begin
			phase_e  = decint_pkg::PH_LEAD;
			neg_e    = 1'b0;
			acc_e    = '0;
			beyond_e = 1'b0;
			count_e  = '0;
		end else begin
			phase_e  = phase_q;
			neg_e    = neg_q;
			acc_e    = acc_q;
			beyond_e = beyond_q;
			count_e  = count_q;
		end

		is_digit = (item_s1.character >= decint_pkg::CH_ZERO) &&
			(item_s1.character <= decint_pkg::CH_NINE);
		is_space = (item_s1.character == decint_pkg::CH_SPACE) ||
			((item_s1.character >= decint_pkg::CH_TAB) &&
			(item_s1.character <= decint_pkg::CH_CR));
		is_sign  = (item_s1.character == decint_pkg::CH_PLUS) ||
			(item_s1.character == decint_pkg::CH_MINUS);
		digit    = item_s1.character[3:0];

		// times ten plus digit as shift-add, with carry-out bits kept
		prod = {1'b0, acc_e, 3'b000} + {3'b000, acc_e, 1'b0} + (ACC_WIDTH+4)'(digit);

		phase_d  = phase_e;
		neg_d    = neg_e;
		acc_d    = acc_e;
		beyond_d = beyond_e;
		take     = 1'b0;

		case (phase_e)
			decint_pkg::PH_IDLE: begin
				take = 1'b0;
			end
			decint_pkg::PH_LEAD: begin
				if (is_space) begin
					take = 1'b1;
				end else if (is_sign) begin
					neg_d   = (item_s1.character == decint_pkg::CH_MINUS);
					phase_d = decint_pkg::PH_SIGN;
					take    = 1'b1;
				end else if (is_digit) begin
					phase_d = decint_pkg::PH_DIGITS;
					take    = 1'b1;
				end
			end
			default: begin
				if (is_digit) begin
					phase_d = decint_pkg::PH_DIGITS;
					take    = 1'b1;
				end
			end
		endcase

		// accumulate; once past the register range, freeze the magnitude
		if (take && is_digit && !beyond_e) begin
			if (prod[ACC_WIDTH+3:ACC_WIDTH] != 4'd0) begin
				beyond_d = 1'b1;
			end else begin
				acc_d = prod[ACC_WIDTH-1:0];
			end
		end

		if (take && (count_e != decint_pkg::COUNT_MAX)) begin
			count_d = count_e + CW'(1);
		end else begin
			count_d = count_e;
		end

		emit = (phase_e != decint_pkg::PH_IDLE) &&
			(!take || item_s1.buffer_end || (count_d >= max_chars_q));
		if (emit) begin
			phase_d = decint_pkg::PH_IDLE;
		end

		// range limits of the selected width
		case (width_mode_q)
			decint_pkg::WMODE_8: begin
				half = 64'h0000_0000_0000_0080;
				umax = 64'h0000_0000_0000_00FF;
			end
			decint_pkg::WMODE_16: begin
				half = 64'h0000_0000_0000_8000;
				umax = 64'h0000_0000_0000_FFFF;
			end
			decint_pkg::WMODE_32: begin
				half = 64'h0000_0000_8000_0000;
				umax = 64'h0000_0000_FFFF_FFFF;
			end
			default: begin
				half = 64'h8000_0000_0000_0000;
				umax = 64'hFFFF_FFFF_FFFF_FFFF;
			end
		endcase

		mag = VW'(acc_d);
		num = neg_d ? (VW'(0) - mag) : mag;

		result.consumed = count_d;
		if (phase_d == decint_pkg::PH_DIGITS || phase_e == decint_pkg::PH_DIGITS ||
			(take && is_digit)) begin
			result.status = decint_pkg::STATUS_OK;
			result.value  = num;
			if (signed_mode_q) begin
				if (neg_d) begin
					if (beyond_d || (mag > half)) begin
						result.status = decint_pkg::STATUS_UNDER;
						result.value  = VW'(0) - half;
					end
				end else if (beyond_d || (mag > (half - VW'(1)))) begin
					result.status = decint_pkg::STATUS_OVER;
					result.value  = half - VW'(1);
				end
			end else if (beyond_d || (num > umax)) begin
				result.status = decint_pkg::STATUS_OVER;
				result.value  = umax;
			end
		end else begin
			// no digits seen: lone sign, blanks or a stray character
			result.status   = decint_pkg::STATUS_NONE;
			result.value    = '0;
			result.consumed = '0;
		end
	end

	// result register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_item_q <= result;
		end
	end

endmodule

// File: hw/rtl/decint_checker.sv
// ----------------------------------------------------------------------------
// decint_checker
// Port-level checks for the decimal integer parser, bound to the top level.
// ----------------------------------------------------------------------------
module decint_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input decint_pkg::out_item_t out_item
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result item changed under stall");

	// no digits gives zero value and zero count
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == decint_pkg::STATUS_NONE) |->
		(out_item.value == '0) && (out_item.consumed == '0))
		else $error("empty parse with nonzero value or count");

	// a parse with digits consumed at least one character
	a_digits_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status != decint_pkg::STATUS_NONE) |->
		(out_item.consumed != '0))
		else $error("digit result with zero consumed count");

	// underflow saturates to a negative number
	a_under_neg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == decint_pkg::STATUS_UNDER) |->
		out_item.value[decint_pkg::VALUE_W-1])
		else $error("underflow value not negative");

endmodule

bind decimal_integer_parser_saturating_top decint_checker u_decint_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
